### rtl/lzw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzw_pkg
// Shared constants and types for the LZW encoder: dictionary geometry,
// request and result payloads, the sequencer states and the dictionary port.
// ----------------------------------------------------------------------------
package lzw_pkg;

    localparam int DICT_ENTRIES = 4096;
    localparam int IDX_W        = $clog2(DICT_ENTRIES);
    localparam int CNT_W        = $clog2(DICT_ENTRIES + 1);
    localparam int CODE_W       = 13;
    localparam int BYTE_W       = 8;

    // Prefix code that stands for the empty string.
    localparam logic [CNT_W-1:0] EMPTY_CODE = CNT_W'(DICT_ENTRIES);
    // First dictionary slot that is not a preset single byte.
    localparam logic [CNT_W-1:0] FIRST_FREE = CNT_W'(256);

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_stream;
    } t_in_item;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              final_code;
    } t_out_item;

    typedef struct packed {
        logic [CNT_W-1:0]  prefix;
        logic [BYTE_W-1:0] byte_val;
    } t_dict_entry;

    typedef struct packed {
        logic              rd_en;
        logic [IDX_W-1:0]  rd_addr;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        t_dict_entry       wr_entry;
    } t_dict_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT,
        S_FLUSH
    } t_state;

endpackage
`default_nettype wire

### rtl/lzw_dict.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzw_dict
// Dictionary store: one write port and one read port with registered data.
// Only slots from the first free code on are ever written or read.
// ----------------------------------------------------------------------------
module lzw_dict import lzw_pkg::*; (
    input  wire logic        i_clk,
    input  wire t_dict_ctl   i_ctl,
    output t_dict_entry      o_rd_entry
);

    t_dict_entry r_mem [DICT_ENTRIES];
    t_dict_entry r_rd_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.wr_addr] <= i_ctl.wr_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_entry <= r_mem[i_ctl.rd_addr];
        end
    end

    assign o_rd_entry = r_rd_entry;

endmodule
`default_nettype wire

### rtl/lzw_encoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzw_encoder
// LZW compression encoder, one byte per request, 13-bit codes out.
//
// Input channel (i_in_valid / o_in_ready / i_in_data) carries one byte or an
// end-of-stream marker. Output channel (o_out_valid / i_out_ready /
// o_out_data) carries zero or one code per request.
// The block takes one request at a time; o_in_ready is high only while the
// sequencer is idle.
// Handling of a request:
//   - byte with an empty prefix: taken as the new prefix, no code.
//   - other bytes: the dictionary is scanned one stored string per cycle
//     through its single read port and one comparator, from the first free
//     code up to the next free code; a hit ends the scan and extends the
//     prefix, a miss stores the new string while there is room.
//   - a miss or an end marker then loads the code into the output register.
// A result sits in an output register; the next request is accepted while
// it waits. If a new code is ready while the old one is still not taken,
// the sequencer holds until the receiver drains the register.
// Reset (synchronous, active low) empties the prefix and the dictionary
// fill count; no clearing pass is needed. An end marker does the same after
// flushing the pending code (4096 when nothing is pending).
// ----------------------------------------------------------------------------
module lzw_encoder import lzw_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_data
);

    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_prefix;
    logic [CNT_W-1:0]   r_next_free;
    logic [BYTE_W-1:0]  r_byte;
    logic [CNT_W-1:0]   r_addr;
    logic               r_pend;
    logic [IDX_W-1:0]   r_pend_idx;
    logic               r_out_valid;
    t_out_item          r_out;

    logic               in_fire;
    logic               out_free;
    logic               scan_issue;
    logic               scan_hit;
    logic               scan_miss;
    logic               load_out;
    logic               dict_room;
    t_out_item          out_item;
    t_dict_ctl          dict_ctl;
    t_dict_entry        rd_entry;

    // Dictionary storage
    lzw_dict u_dict (
        .i_clk      (i_clk),
        .i_ctl      (dict_ctl),
        .o_rd_entry (rd_entry)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign dict_room  = (r_next_free < CNT_W'(DICT_ENTRIES));

    // Shared compare unit: one stored string per cycle against (prefix, byte).
    // Single-byte codes below the first free code are never stored, so the
    // scan starts at the first free code.
    assign scan_issue = (r_state == S_SCAN) && (r_addr < r_next_free);
    assign scan_hit   = (r_state == S_SCAN) && r_pend &&
                        (rd_entry.prefix == r_prefix) &&
                        (rd_entry.byte_val == r_byte);
    assign scan_miss  = (r_state == S_SCAN) && !r_pend && !(r_addr < r_next_free);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    priority if (i_in_data.end_of_stream) begin
                        n_state = S_FLUSH;
                    end else if (r_prefix != EMPTY_CODE) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SCAN: begin
                priority if (scan_hit) begin
                    n_state = S_IDLE;
                end else if (scan_miss) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_EMIT, S_FLUSH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        load_out            = 1'b0;
        out_item.code       = CODE_W'(r_prefix);
        out_item.final_code = 1'b0;
        dict_ctl.rd_en      = scan_issue;
        dict_ctl.rd_addr    = r_addr[IDX_W-1:0];
        dict_ctl.wr_en      = 1'b0;
        dict_ctl.wr_addr    = r_next_free[IDX_W-1:0];
        dict_ctl.wr_entry.prefix   = r_prefix;
        dict_ctl.wr_entry.byte_val = r_byte;
        unique case (r_state)
            S_EMIT: begin
                load_out       = out_free;
                dict_ctl.wr_en = out_free && dict_room;
            end
            S_FLUSH: begin
                load_out            = out_free;
                out_item.final_code = 1'b1;
            end
            S_IDLE, S_SCAN: begin
                load_out = 1'b0;
            end
            default: load_out = 1'b0;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prefix    <= EMPTY_CODE;
            r_next_free <= FIRST_FREE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= scan_issue;

            // Track the current string
            if (in_fire && !i_in_data.end_of_stream && (r_prefix == EMPTY_CODE)) begin
                r_prefix <= CNT_W'(i_in_data.data_byte);
            end else if (scan_hit) begin
                r_prefix <= CNT_W'(r_pend_idx);
            end else if (r_state == S_EMIT && out_free) begin
                r_prefix <= CNT_W'(r_byte);
            end else if (r_state == S_FLUSH && out_free) begin
                r_prefix <= EMPTY_CODE;
            end

            // Grow the dictionary until full; drop it on end of stream
            if (dict_ctl.wr_en) begin
                r_next_free <= r_next_free + CNT_W'(1);
            end else if (r_state == S_FLUSH && out_free) begin
                r_next_free <= FIRST_FREE;
            end

            // Hold the result until the receiver takes it
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_byte <= i_in_data.data_byte;
            r_addr <= FIRST_FREE;
        end else if (scan_issue) begin
            r_addr <= r_addr + CNT_W'(1);
        end
        if (scan_issue) begin
            r_pend_idx <= r_addr[IDX_W-1:0];
        end
        if (load_out) begin
            r_out <= out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Fill count stays within the stored range
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next_free >= FIRST_FREE) && (r_next_free <= CNT_W'(DICT_ENTRIES)))
        else $error("next free code out of range");

    // A scan only runs for a non-empty prefix
    a_scan_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_prefix != EMPTY_CODE))
        else $error("scan with empty prefix");

    // Never overwrite a code the receiver has not taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !load_out)
        else $error("output register overwritten");

    // End of stream leads straight to the flush
    a_eos_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in_data.end_of_stream) |=> (r_state == S_FLUSH))
        else $error("end of stream did not flush");

    // A flush restores the reset prefix and fill count and leaves the final code valid
    a_flush_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH && out_free) |=>
        (r_prefix == EMPTY_CODE) && (r_next_free == FIRST_FREE) && r_out_valid)
        else $error("flush did not restore reset state");

endmodule
`default_nettype wire

### tb/sv/lzw_code_check.sv
// ----------------------------------------------------------------------------
// lzw_code_check
// Watches both channels of the LZW encoder, keeps its own dictionary and
// prefix, and compares every code that leaves the block with the oldest
// predicted code.
// ----------------------------------------------------------------------------
module lzw_code_check import lzw_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire logic      i_in_ready,
    input  wire t_in_item  i_in_data,
    input  wire logic      i_out_valid,
    input  wire logic      i_out_ready,
    input  wire t_out_item i_out_data,
    output int             o_fail_count,
    output int             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Dictionary as a trie: children of each prefix code in a linked list.
    logic [BYTE_W-1:0] entry_byte   [0:DICT_ENTRIES-1];
    int                next_sibling [0:DICT_ENTRIES-1];
    int                first_child  [0:DICT_ENTRIES];
    int                dict_fill;
    logic [CNT_W-1:0]  prefix_code;
    t_out_item         expected_codes [$];
    t_out_item         oldest_code;

    task automatic report_mismatch(input string what, input logic [CODE_W-1:0] got,
                                   input logic [CODE_W-1:0] want);
        $display("[%0t] mismatch: %s got %0h, want %0h", $time, what, got, want);
        o_fail_count = o_fail_count + 1;
    endtask

    function void restart_dictionary();
        for (int p = 0; p <= DICT_ENTRIES; p++) first_child[p] = -1;
        dict_fill   = int'(FIRST_FREE);
        prefix_code = EMPTY_CODE;
    endfunction

    // Code of the string prefix+byte, or -1 when it is not stored.
    function int child_code(input logic [CNT_W-1:0] prefix, input logic [BYTE_W-1:0] b);
        int e;
        if (prefix == EMPTY_CODE) return int'(b);
        e = first_child[prefix];
        while (e >= 0) begin
            if (entry_byte[e] == b) return e;
            e = next_sibling[e];
        end
        return -1;
    endfunction

    function void encode_request(input t_in_item req);
        t_out_item code_out;
        int        hit;
        hit = child_code(prefix_code, req.data_byte);
        if (req.end_of_stream) begin
            code_out.code       = CODE_W'(prefix_code);
            code_out.final_code = 1'b1;
            expected_codes.push_back(code_out);
            restart_dictionary();
        end else if (hit >= 0) begin
            prefix_code = CNT_W'(hit);
        end else begin
            // Full dictionary: drop the new string, still emit the prefix.
            if (dict_fill < DICT_ENTRIES) begin
                entry_byte[dict_fill]    = req.data_byte;
                next_sibling[dict_fill]  = first_child[prefix_code];
                first_child[prefix_code] = dict_fill;
                dict_fill                = dict_fill + 1;
            end
            code_out.code       = CODE_W'(prefix_code);
            code_out.final_code = 1'b0;
            expected_codes.push_back(code_out);
            prefix_code = CNT_W'(req.data_byte);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_dictionary();
            expected_codes.delete();
        end else begin
            // A code taken at this edge always belongs to an earlier request.
            if (i_out_valid && i_out_ready) begin
                if (expected_codes.size() == 0) begin
                    report_mismatch("code with none pending", i_out_data.code, '0);
                end else begin
                    oldest_code = expected_codes.pop_front();
                    if (i_out_data.code !== oldest_code.code)
                        report_mismatch("code", i_out_data.code, oldest_code.code);
                    if (i_out_data.final_code !== oldest_code.final_code)
                        report_mismatch("final_code", CODE_W'(i_out_data.final_code),
                                        CODE_W'(oldest_code.final_code));
                end
            end
            if (i_in_valid && i_in_ready) encode_request(i_in_data);
        end
        o_pending = expected_codes.size();
    end

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the LZW encoder: directed byte patterns, random
// streams with idling on both channels and a long receiver hold-off.
// Checking lives in lzw_code_check.
// ----------------------------------------------------------------------------
module tb_top import lzw_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    // Even if every request scanned a full dictionary under the longest
    // stalls, the run stays several times below this.
    localparam int CYCLE_LIMIT  = 3_000_000;
    // Longest scan the block can do, plus margin, to catch stray codes.
    localparam int DRAIN_CYCLES = 4100;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_data   = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_data;

    int fail_count;
    int codes_pending;
    int cycle_count = 0;
    int requests_sent = 0;
    int rx_hold_len = 0;   // set by the stimulus, consumed by the receiver
    bit idle_en = 1'b1;

    always #2 clk = ~clk;

    lzw_encoder dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    lzw_code_check code_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (codes_pending)
    );

    // Hard stop: a hung handshake or a lost code ends the run here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Offer one request; called at a falling edge, returns at a falling edge
    // after acceptance. Valid is only dropped for an idle burst, never
    // lowered and raised in the same step.
    task automatic send_request(input logic eos, input logic [BYTE_W-1:0] b);
        t_in_item req;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        req.data_byte     = b;
        req.end_of_stream = eos;
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        requests_sent = requests_sent + 1;
        @(negedge clk);
    endtask

    // One stream closed by an end request. Small alphabets repeat strings
    // and grow long codes; full-range bytes mostly miss.
    task automatic send_stream(input int len, input bit full_range);
        logic [BYTE_W-1:0] letters [4];
        int                span;
        foreach (letters[i]) letters[i] = BYTE_W'($urandom);
        span = $urandom_range(1, 3);
        for (int i = 0; i < len; i++)
            send_request(1'b0, full_range ? BYTE_W'($urandom)
                                          : letters[$urandom_range(0, span)]);
        send_request(1'b1, BYTE_W'($urandom));
    endtask

    task automatic run_random(input int count);
        int stop_at;
        stop_at = requests_sent + count;
        while (requests_sent < stop_at) begin
            // Stray end requests flush an empty prefix.
            if ($urandom_range(0, 7) == 0)
                send_request(1'b1, BYTE_W'($urandom));
            else
                send_stream($urandom_range(1, 24), $urandom_range(0, 3) == 0);
        end
    endtask

    // Receiver: random ready bursts, or one long hold-off when asked.
    initial begin : rx_side
        int span;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            if (rx_hold_len > 0) begin
                span        = rx_hold_len;
                rx_hold_len = 0;
                out_ready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 3) == 0) begin
                span = $urandom_range(1, 16);
                out_ready <= 1'b0;
            end else begin
                span = idle_en ? $urandom_range(1, 16) : 1;
                out_ready <= 1'b1;
            end
            repeat (span) @(negedge clk);
        end
    end

    initial begin : stimulus
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: end with nothing pending, twice in a row.
        send_request(1'b1, 8'hA5);
        send_request(1'b1, 8'h00);
        // Extremes 00/FF: first byte on an empty prefix, misses that add
        // strings, then hits on those strings and longer chains.
        send_request(1'b0, 8'h00);
        send_request(1'b0, 8'hFF);
        send_request(1'b0, 8'h00);
        send_request(1'b0, 8'hFF);
        send_request(1'b0, 8'h00);
        send_request(1'b0, 8'hFF);
        send_request(1'b0, 8'h00);
        send_request(1'b0, 8'hFF);
        send_request(1'b0, 8'hFF);
        send_request(1'b0, 8'hFF);
        send_request(1'b0, 8'hFF);
        // Flush a pending single byte; data is ignored here.
        send_request(1'b1, 8'hFF);
        // After the end the old strings must be gone: 00,FF misses again.
        send_request(1'b0, 8'h80);
        send_request(1'b0, 8'h00);
        send_request(1'b0, 8'hFF);
        send_request(1'b0, 8'h55);
        send_request(1'b0, 8'hAA);
        send_request(1'b0, 8'h55);
        send_request(1'b0, 8'hAA);
        send_request(1'b0, 8'h55);
        send_request(1'b1, 8'h00);

        run_random(15);

        // Hold the receiver off while full-range bytes keep coming, so the
        // output register stays full and the block stalls its input.
        rx_hold_len = 400;
        send_stream(30, 1'b1);

        // Drop valid and wait until every predicted code has arrived.
        in_valid <= 1'b0;
        @(negedge clk);
        while (codes_pending != 0) @(negedge clk);

        run_random(30);

        // Last part runs without idling on either side.
        idle_en = 1'b0;
        run_random(20);

        in_valid <= 1'b0;
        while (codes_pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
